/* sv/i2cebm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cebm_pkg
// Shared constants for the I2C EEPROM byte master: sequencer step codes,
// field widths and control byte bits.
// ----------------------------------------------------------------------------
package i2cebm_pkg;

  localparam int StepW  = 4;
  localparam int CntW   = 4;
  localparam int PhaseW = 2;
  localparam int ByteW  = 8;
  localparam int DevW   = 7;

  typedef logic [StepW-1:0]  step_t;
  typedef logic [CntW-1:0]   cnt_t;
  typedef logic [PhaseW-1:0] phase_t;
  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [DevW-1:0]   dev_t;

  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_START1 = 4'd1;
  localparam step_t STEP_CTRLW  = 4'd2;
  localparam step_t STEP_ADDR   = 4'd3;
  localparam step_t STEP_DATA   = 4'd4;
  localparam step_t STEP_START2 = 4'd5;
  localparam step_t STEP_CTRLR  = 4'd6;
  localparam step_t STEP_READ   = 4'd7;
  localparam step_t STEP_STOP   = 4'd8;

  localparam cnt_t  BITS_PER_BYTE = 4'd8;
  localparam dev_t  DEV_ADDR_RST  = 7'h50;
  localparam logic  RD_BIT        = 1'b1;
  localparam logic  WR_BIT        = 1'b0;

endpackage

/* sv/i2c_eeprom_byte_master.sv */
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master
// Bit-level I2C master for a 256-byte serial EEPROM: byte write and random
// byte read, one bus phase per input beat.
// ----------------------------------------------------------------------------
// Each input beat is one bus delay tick and yields exactly one output beat
// with the SCL/SDA levels for that tick, busy, done and the last read byte.
// The sequencer state and the output beat are both updated in the cycle the
// input beat is taken, so one beat is accepted per clock while the output
// register is empty or its beat is taken; a beat that is not taken is held
// there and blocks further input beats until it is taken. A byte write takes
// 3 + 3*18 + 4 ticks; a random read 3 + 2*18 + 3 + 18 + 18 + 4 ticks.
// ACK bits from the slave are clocked with SDA released and not checked.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_master
  import i2cebm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_start_request,
  input  logic        in_func,
  input  logic [7:0]  in_word_address,
  input  logic [7:0]  in_write_data,
  input  logic        in_sda_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_scl_level,
  output logic        out_sda_release,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_read_data
);

  dev_t   dev_addr_r;
  step_t  step_r,  step_nxt;
  cnt_t   cnt_r,   cnt_nxt;
  phase_t phase_r, phase_nxt;
  byte_t  shift_r, shift_nxt;
  logic   op_r,    op_nxt;
  byte_t  addr_r,  addr_nxt;
  byte_t  data_r,  data_nxt;
  byte_t  rx_r,    rx_nxt;

  logic   out_valid_r;
  logic   scl_r, scl_nxt;
  logic   sda_r, sda_nxt;
  logic   busy_r, busy_nxt;
  logic   done_r, done_nxt;

  logic   take;
  byte_t  ctrl;

  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;
  assign ctrl     = {dev_addr_r, WR_BIT};

  always_comb begin
    step_t  st;
    phase_t ph;
    cnt_t   ct;
    byte_t  sh;
    st        = step_r;
    ph        = phase_r;
    ct        = cnt_r;
    sh        = shift_r;
    op_nxt    = op_r;
    addr_nxt  = addr_r;
    data_nxt  = data_r;
    rx_nxt    = rx_r;
    scl_nxt   = 1'b1;
    sda_nxt   = 1'b1;
    busy_nxt  = 1'b1;
    done_nxt  = 1'b0;

    if (st > STEP_STOP) begin
      st = STEP_IDLE;
    end
    if (st == STEP_IDLE) begin
      if (in_start_request) begin
        op_nxt   = in_func;
        addr_nxt = in_word_address;
        data_nxt = in_write_data;
        st       = STEP_START1;
        ph       = '0;
        ct       = '0;
      end else begin
        busy_nxt = 1'b0;
      end
    end

    step_nxt  = st;
    phase_nxt = ph;
    cnt_nxt   = ct;
    shift_nxt = sh;

    case (st)
      STEP_START1, STEP_START2: begin
        if (ph == 2'd0) begin
          scl_nxt = (st == STEP_START1);
          sda_nxt = 1'b1;
        end else begin
          scl_nxt = 1'b1;
          sda_nxt = !ph[1];
        end
        if (ph < 2'd2) begin
          phase_nxt = ph + 2'd1;
        end else begin
          step_nxt  = (st == STEP_START1) ? STEP_CTRLW : STEP_CTRLR;
          shift_nxt = (st == STEP_START1) ? ctrl : {dev_addr_r, RD_BIT};
          cnt_nxt   = '0;
          phase_nxt = '0;
        end
      end
      STEP_CTRLW, STEP_ADDR, STEP_DATA, STEP_CTRLR: begin
        scl_nxt = ph[0];
        if (ct < BITS_PER_BYTE) begin
          sda_nxt = sh[ByteW-1];
          if (ph[0]) begin
            shift_nxt = {sh[ByteW-2:0], 1'b0};
            cnt_nxt   = ct + 4'd1;
            phase_nxt = '0;
          end else begin
            phase_nxt = 2'd1;
          end
        end else begin
          sda_nxt = 1'b1;
          if (!ph[0]) begin
            phase_nxt = 2'd1;
          end else begin
            cnt_nxt   = '0;
            phase_nxt = '0;
            case (st)
              STEP_CTRLW: begin
                step_nxt  = STEP_ADDR;
                shift_nxt = addr_r;
              end
              STEP_ADDR: begin
                if (op_r) begin
                  step_nxt = STEP_START2;
                end else begin
                  step_nxt  = STEP_DATA;
                  shift_nxt = data_r;
                end
              end
              STEP_DATA: begin
                step_nxt  = STEP_STOP;
                shift_nxt = '0;
              end
              default: begin
                step_nxt  = STEP_READ;
                shift_nxt = '0;
              end
            endcase
          end
        end
      end
      STEP_READ: begin
        scl_nxt = ph[0];
        sda_nxt = 1'b1;
        if (!ph[0]) begin
          phase_nxt = 2'd1;
        end else if (ct < BITS_PER_BYTE) begin
          shift_nxt = {sh[ByteW-2:0], in_sda_sample};
          cnt_nxt   = ct + 4'd1;
          if (ct == BITS_PER_BYTE - 4'd1) begin
            rx_nxt = {sh[ByteW-2:0], in_sda_sample};
          end
          phase_nxt = '0;
        end else begin
          step_nxt  = STEP_STOP;
          shift_nxt = '0;
          cnt_nxt   = '0;
          phase_nxt = '0;
        end
      end
      STEP_STOP: begin
        scl_nxt = ph[1];
        sda_nxt = (ph == 2'd0) || (ph == 2'd3);
        if (ph == 2'd3) begin
          done_nxt  = 1'b1;
          step_nxt  = STEP_IDLE;
          phase_nxt = '0;
          cnt_nxt   = '0;
        end else begin
          phase_nxt = ph + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= DEV_ADDR_RST;
      step_r      <= STEP_IDLE;
      cnt_r       <= '0;
      phase_r     <= '0;
      shift_r     <= '0;
      op_r        <= 1'b0;
      addr_r      <= '0;
      data_r      <= '0;
      rx_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dev_addr_r <= cfg_wr_data;
      end
      if (take) begin
        step_r  <= step_nxt;
        cnt_r   <= cnt_nxt;
        phase_r <= phase_nxt;
        shift_r <= shift_nxt;
        op_r    <= op_nxt;
        addr_r  <= addr_nxt;
        data_r  <= data_nxt;
        rx_r    <= rx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      scl_r  <= scl_nxt;
      sda_r  <= sda_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_scl_level   = scl_r;
  assign out_sda_release = sda_r;
  assign out_busy_res    = busy_r;
  assign out_done_res    = done_r;
  assign out_read_data   = rx_r;

endmodule

/* tb/tb_i2c_eeprom_byte_master.sv */
// ----------------------------------------------------------------------------
// tb_i2c_eeprom_byte_master
// Self-checking bench for the I2C EEPROM byte master. A queue of bus ticks
// feeds a valid/ready driver; every accepted tick runs through a cycle-true
// model of the sequencer, and each output beat is compared field by field
// with the oldest predicted beat. Directed write and read transfers come
// first, then random transfers and noise under several device addresses,
// with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_i2c_eeprom_byte_master;
  import i2cebm_pkg::*;

  localparam int WR_TICKS    = 61;
  localparam int RD_TICKS    = 82;
  localparam int HOLD_CYCLES = 90;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic  start_request;
    logic  func;
    byte_t word_address;
    byte_t write_data;
    logic  sda_sample;
  } tick_item_t;

  typedef struct packed {
    logic  scl;
    logic  sda;
    logic  busy;
    logic  done;
    byte_t rdata;
  } bus_beat_t;

  logic  clk;
  logic  rst_n = 1'b0;
  logic  cfg_wr_en = 1'b0;
  dev_t  cfg_wr_data = '0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  logic  in_start_request = 1'b0;
  logic  in_func = 1'b0;
  byte_t in_word_address = '0;
  byte_t in_write_data = '0;
  logic  in_sda_sample = 1'b1;
  logic  out_valid;
  logic  out_ready = 1'b0;
  logic  out_scl_level;
  logic  out_sda_release;
  logic  out_busy_res;
  logic  out_done_res;
  byte_t out_read_data;

  tick_item_t pending[$];
  bus_beat_t  beats_due[$];
  int         pushed_cnt = 0;
  int         taken_cnt = 0;
  int         beat_cnt = 0;
  int         fail_cnt = 0;
  int         cycle_cnt = 0;
  int         gap_odds = 0;
  int         tx_gap = 0;
  int         rx_gap = 0;
  int         hold_cnt = 0;
  logic       hold_req = 1'b0;
  logic       hold_done = 1'b0;

  // sequencer model state
  step_t  seq_step;
  cnt_t   bit_cnt;
  phase_t tick_ph;
  byte_t  shreg;
  logic   lat_op;
  byte_t  lat_addr;
  byte_t  lat_data;
  byte_t  rx_byte;
  dev_t   dev_addr;

  i2c_eeprom_byte_master u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_start_request (in_start_request),
    .in_func          (in_func),
    .in_word_address  (in_word_address),
    .in_write_data    (in_write_data),
    .in_sda_sample    (in_sda_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_scl_level    (out_scl_level),
    .out_sda_release  (out_sda_release),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_read_data    (out_read_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void load_byte(input step_t nxt_step, input byte_t val);
    seq_step = nxt_step;
    shreg    = val;
    bit_cnt  = '0;
    tick_ph  = '0;
  endfunction

  // advance the sequencer model by one tick and queue the beat it drives
  function automatic void bus_tick(input tick_item_t it);
    bus_beat_t b;
    b.scl  = 1'b1;
    b.sda  = 1'b1;
    b.busy = 1'b1;
    b.done = 1'b0;
    if (seq_step > STEP_STOP) seq_step = STEP_IDLE;
    if (seq_step == STEP_IDLE) begin
      if (it.start_request) begin
        lat_op   = it.func;
        lat_addr = it.word_address;
        lat_data = it.write_data;
        seq_step = STEP_START1;
        tick_ph  = '0;
        bit_cnt  = '0;
      end else begin
        b.busy = 1'b0;
      end
    end
    case (seq_step)
      STEP_START1, STEP_START2: begin
        if (tick_ph == 2'd0) begin
          b.scl = (seq_step == STEP_START1);
          b.sda = 1'b1;
        end else begin
          b.scl = 1'b1;
          b.sda = (tick_ph < 2'd2);
        end
        if (tick_ph < 2'd2) tick_ph = tick_ph + 2'd1;
        else if (seq_step == STEP_START1) load_byte(STEP_CTRLW, {dev_addr, WR_BIT});
        else load_byte(STEP_CTRLR, {dev_addr, RD_BIT});
      end
      STEP_CTRLW, STEP_ADDR, STEP_DATA, STEP_CTRLR: begin
        tick_ph = tick_ph & 2'd1;
        b.scl   = tick_ph[0];
        if (bit_cnt < BITS_PER_BYTE) begin
          b.sda = shreg[7];
          if (tick_ph[0]) begin
            shreg   = shreg << 1;
            bit_cnt = bit_cnt + 4'd1;
            tick_ph = '0;
          end else begin
            tick_ph = 2'd1;
          end
        end else begin
          b.sda = 1'b1;
          if (!tick_ph[0]) begin
            tick_ph = 2'd1;
          end else begin
            case (seq_step)
              STEP_CTRLW: load_byte(STEP_ADDR, lat_addr);
              STEP_ADDR: begin
                if (lat_op) begin
                  seq_step = STEP_START2;
                  tick_ph  = '0;
                  bit_cnt  = '0;
                end else begin
                  load_byte(STEP_DATA, lat_data);
                end
              end
              STEP_DATA: load_byte(STEP_STOP, '0);
              default:   load_byte(STEP_READ, '0);
            endcase
          end
        end
      end
      STEP_READ: begin
        tick_ph = tick_ph & 2'd1;
        b.scl   = tick_ph[0];
        b.sda   = 1'b1;
        if (!tick_ph[0]) begin
          tick_ph = 2'd1;
        end else if (bit_cnt < BITS_PER_BYTE) begin
          shreg   = {shreg[6:0], it.sda_sample};
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt == BITS_PER_BYTE) rx_byte = shreg;
          tick_ph = '0;
        end else begin
          load_byte(STEP_STOP, '0);
        end
      end
      STEP_STOP: begin
        b.scl = (tick_ph >= 2'd2);
        b.sda = (tick_ph == 2'd0 || tick_ph == 2'd3);
        if (tick_ph == 2'd3) begin
          b.done   = 1'b1;
          seq_step = STEP_IDLE;
          tick_ph  = '0;
          bit_cnt  = '0;
        end else begin
          tick_ph = tick_ph + 2'd1;
        end
      end
      default: ;
    endcase
    b.rdata = rx_byte;
    beats_due.push_back(b);
  endfunction

  // driver
  always @(posedge clk) begin : drive_in
    tick_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else if (in_valid && !in_ready) begin
      // hold the beat until taken
    end else if (tx_gap != 0) begin
      in_valid <= 1'b0;
      tx_gap   <= tx_gap - 1;
    end else if (pending.size() == 0) begin
      in_valid <= 1'b0;
    end else if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
      in_valid <= 1'b0;
      tx_gap   <= $urandom_range(13, 0);
    end else begin
      nxt = pending.pop_front();
      in_valid         <= 1'b1;
      in_start_request <= nxt.start_request;
      in_func          <= nxt.func;
      in_word_address  <= nxt.word_address;
      in_write_data    <= nxt.write_data;
      in_sda_sample    <= nxt.sda_sample;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap    <= 0;
      hold_cnt  <= 0;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else if (rx_gap != 0) begin
      out_ready <= 1'b0;
      rx_gap    <= rx_gap - 1;
    end else if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
      out_ready <= 1'b0;
      rx_gap    <= $urandom_range(13, 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin : watch_bus
    bus_beat_t got;
    bus_beat_t want;
    if (!rst_n) begin
      seq_step = STEP_IDLE;
      bit_cnt  = '0;
      tick_ph  = '0;
      shreg    = '0;
      lat_op   = 1'b0;
      lat_addr = '0;
      lat_data = '0;
      rx_byte  = '0;
      dev_addr = DEV_ADDR_RST;
    end else begin
      if (in_valid && in_ready) begin
        bus_tick('{in_start_request, in_func, in_word_address, in_write_data,
                   in_sda_sample});
        taken_cnt++;
      end
      if (cfg_wr_en) dev_addr = cfg_wr_data;
      if (out_valid && out_ready) begin
        got = '{out_scl_level, out_sda_release, out_busy_res, out_done_res,
                out_read_data};
        if (beats_due.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("beat %0d: unexpected output beat %p", beat_cnt, got);
        end else begin
          want = beats_due.pop_front();
          if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display("beat %0d: exp scl %b sda %b busy %b done %b data %02h, got scl %b sda %b busy %b done %b data %02h",
                       beat_cnt, want.scl, want.sda, want.busy, want.done, want.rdata,
                       got.scl, got.sda, got.busy, got.done, got.rdata);
          end
        end
        beat_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_tick(input logic req, input logic fn, input byte_t addr,
                           input byte_t data, input logic sda);
    pending.push_back('{req, fn, addr, data, sda});
    pushed_cnt++;
  endtask

  task automatic queue_transfer(input logic rd, input byte_t addr, input byte_t data,
                                input logic rand_fill, input logic sda_lvl);
    int len;
    len = rd ? RD_TICKS : WR_TICKS;
    push_tick(1'b1, rd, addr, data, rand_fill ? 1'($urandom) : sda_lvl);
    for (int k = 1; k < len; k++) begin
      if (rand_fill)
        push_tick(1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      else
        push_tick(1'b1, ~rd, ~addr, ~data, sda_lvl);
    end
  endtask

  task automatic random_traffic(input int n_ticks);
    int stop_at;
    stop_at = pushed_cnt + n_ticks;
    while (pushed_cnt < stop_at) begin
      if ($urandom_range(9, 0) == 0) begin
        repeat ($urandom_range(4, 1))
          push_tick(1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        queue_transfer(1'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1'b0);
        repeat ($urandom_range(3, 0))
          push_tick(1'b0, 1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // wait for every beat to return, padding with idle ticks until the bus is idle
  task automatic settle_bus();
    while (1) begin
      while (taken_cnt != pushed_cnt || beats_due.size() != 0) @(posedge clk);
      if (seq_step == STEP_IDLE) break;
      push_tick(1'b0, 1'b0, '0, '0, 1'b1);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_dev_addr(input dev_t val);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset device address
    gap_odds = 5;
    push_tick(1'b0, 1'b1, 8'hff, 8'hff, 1'b0);
    push_tick(1'b0, 1'b0, 8'h00, 8'h00, 1'b1);
    queue_transfer(1'b0, 8'h00, 8'h00, 1'b0, 1'b0);
    queue_transfer(1'b0, 8'hff, 8'hff, 1'b0, 1'b1);
    queue_transfer(1'b1, 8'h00, 8'h00, 1'b0, 1'b1);
    queue_transfer(1'b1, 8'hff, 8'hff, 1'b0, 1'b0);
    queue_transfer(1'b1, 8'h5a, 8'ha5, 1'b1, 1'b0);
    settle_bus();

    set_dev_addr(7'h7f);
    gap_odds = 4;
    random_traffic(90);
    hold_req = 1'b1;
    settle_bus();

    set_dev_addr(7'h00);
    gap_odds = 8;
    random_traffic(90);
    settle_bus();

    set_dev_addr(7'($urandom));
    gap_odds = 2;
    random_traffic(90);
    settle_bus();

    // no idling from here on
    set_dev_addr(7'($urandom));
    gap_odds = 0;
    random_traffic(70);
    settle_bus();

    repeat (20) @(posedge clk);
    if (fail_cnt == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
